// ----- rtl/core/rotate_shift_bit_flag_unit_core_macros.svh -----
// Assertion macros for the bit, rotate and flag unit RTL.
`ifndef ROTATE_SHIFT_BIT_FLAG_UNIT_CORE_MACROS_SVH
`define ROTATE_SHIFT_BIT_FLAG_UNIT_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define RSBF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define RSBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rsbf_pkg.sv -----
// Types and constants of the bit, rotate and flag unit.
`default_nettype none

package rsbf_pkg;

	// CB opcode groups, bits 7:6
	typedef enum logic [1:0] {
		GRP_ROT = 2'd0,
		GRP_BIT = 2'd1,
		GRP_RES = 2'd2,
		GRP_SET = 2'd3
	} cb_grp_t;

	// CB rotate and shift operations, bits 5:3
	typedef enum logic [2:0] {
		ROT_RLC  = 3'd0,
		ROT_RRC  = 3'd1,
		ROT_RL   = 3'd2,
		ROT_RR   = 3'd3,
		ROT_SLA  = 3'd4,
		ROT_SRA  = 3'd5,
		ROT_SWAP = 3'd6,
		ROT_SRL  = 3'd7
	} rot_op_t;

	// Accumulator operations, bits 5:3
	typedef enum logic [2:0] {
		ACC_RLCA = 3'd0,
		ACC_RRCA = 3'd1,
		ACC_RLA  = 3'd2,
		ACC_RRA  = 3'd3,
		ACC_DAA  = 3'd4,
		ACC_CPL  = 3'd5,
		ACC_SCF  = 3'd6,
		ACC_CCF  = 3'd7
	} acc_op_t;

	localparam logic       KIND_CB  = 1'b0;
	localparam logic [2:0] REG_HL   = 3'd6;

	localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;
	localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;

	localparam logic [2:0] CYC_ACC     = 3'd1;
	localparam logic [2:0] CYC_CB_REG  = 3'd2;
	localparam logic [2:0] CYC_BIT_MEM = 3'd3;
	localparam logic [2:0] CYC_CB_MEM  = 3'd4;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [7:0] value;
		logic       writes_back;
		flags_t     flags;
		logic [2:0] cycles;
	} rsbf_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/rotate_shift_bit_flag_unit_core.sv -----
// Two register stages: the input register (stage 1) and the result register (stage 2).
// Throughput: one item per cycle while m_tready stays high; the only path is the single-pass decode between the two.
// A stalled output holds its item; the input register refills as soon as it moves on.
// Reset: arst_n asynchronous, active low; clears both valid bits, payload is not reset.
// Top level of the bit, rotate and flag unit.
`default_nettype none

`include "rotate_shift_bit_flag_unit_core_macros.svh"

module rotate_shift_bit_flag_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] op_code, [15:8] operand, [16] zero_in, [17] subtract_in,
	// [18] half_in, [19] carry_in, [23:20] zero
	input  wire logic [23:0] s_tdata,
	// [0] kind
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] result, [8] writes_back, [9] zero_out, [10] subtract_out,
	// [11] half_out, [12] carry_out, [15:13] machine_cycles
	output logic [15:0]      m_tdata
);
	import rsbf_pkg::*;

	// Stage 1: input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] op_s1;
	logic [7:0] operand_s1;
	flags_t     flags_s1;

	// Stage 2: result register
	logic       valid_s2;
	rsbf_res_t  res_s2;

	logic      adv_s1;   // stage 1 item moves into stage 2
	rsbf_res_t res_c;

	// Stage 2 frees when empty or taken; stage 1 takes an item when it empties.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1    <= s_tuser[0];
			op_s1      <= s_tdata[7:0];
			operand_s1 <= s_tdata[15:8];
			flags_s1   <= '{z: s_tdata[16], n: s_tdata[17], h: s_tdata[18], c: s_tdata[19]};
		end
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	// Single-pass decode and evaluation of the stage 1 item.
	always_comb begin
		logic [2:0] sel;
		logic       msb;
		logic       lsb;
		logic       mem;
		logic [7:0] bit_mask;
		logic [7:0] adj;
		logic       high_fix;

		sel      = op_s1[5:3];
		msb      = operand_s1[7];
		lsb      = operand_s1[0];
		mem      = (op_s1[2:0] == REG_HL);
		bit_mask = 8'(1) << sel;
		adj      = 8'h00;
		high_fix = 1'b0;

		res_c.value       = operand_s1;
		res_c.writes_back = 1'b1;
		res_c.flags       = flags_s1;
		res_c.cycles      = CYC_ACC;

		if (kind_s1 == KIND_CB) begin
			res_c.cycles = mem ? CYC_CB_MEM : CYC_CB_REG;
			unique case (cb_grp_t'(op_s1[7:6]))
				GRP_BIT: begin
					// test only: flags change, value untouched
					res_c.flags.z     = !(|(operand_s1 & bit_mask));
					res_c.flags.n     = 1'b0;
					res_c.flags.h     = 1'b1;
					res_c.writes_back = 1'b0;
					res_c.cycles      = mem ? CYC_BIT_MEM : CYC_CB_REG;
				end
				GRP_RES: res_c.value = operand_s1 & ~bit_mask;
				GRP_SET: res_c.value = operand_s1 | bit_mask;
				GRP_ROT: begin
					unique case (rot_op_t'(sel))
						ROT_RLC:  begin
							res_c.value = {operand_s1[6:0], msb};
							res_c.flags.c = msb;
						end
						ROT_RRC:  begin
							res_c.value = {lsb, operand_s1[7:1]};
							res_c.flags.c = lsb;
						end
						ROT_RL:   begin
							res_c.value = {operand_s1[6:0], flags_s1.c};
							res_c.flags.c = msb;
						end
						ROT_RR:   begin
							res_c.value = {flags_s1.c, operand_s1[7:1]};
							res_c.flags.c = lsb;
						end
						ROT_SLA:  begin
							res_c.value = {operand_s1[6:0], 1'b0};
							res_c.flags.c = msb;
						end
						ROT_SRA:  begin
							res_c.value = {msb, operand_s1[7:1]};
							res_c.flags.c = lsb;
						end
						ROT_SWAP: begin
							res_c.value = {operand_s1[3:0], operand_s1[7:4]};
							res_c.flags.c = 1'b0;
						end
						ROT_SRL:  begin
							res_c.value = {1'b0, operand_s1[7:1]};
							res_c.flags.c = lsb;
						end
					endcase
					res_c.flags.z = (res_c.value == 8'h00);
					res_c.flags.n = 1'b0;
					res_c.flags.h = 1'b0;
				end
			endcase
		end else begin
			unique case (acc_op_t'(sel))
				ACC_RLCA: begin
					res_c.value = {operand_s1[6:0], msb};
					res_c.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: msb};
				end
				ACC_RRCA: begin
					res_c.value = {lsb, operand_s1[7:1]};
					res_c.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: lsb};
				end
				ACC_RLA:  begin
					res_c.value = {operand_s1[6:0], flags_s1.c};
					res_c.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: msb};
				end
				ACC_RRA:  begin
					res_c.value = {flags_s1.c, operand_s1[7:1]};
					res_c.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: lsb};
				end
				ACC_DAA:  begin
					if (flags_s1.n) begin
						// after a subtraction: undo by the flags alone, carry kept
						adj = (flags_s1.h ? DAA_LOW_ADJ : 8'h00)
						    | (flags_s1.c ? DAA_HIGH_ADJ : 8'h00);
						res_c.value = operand_s1 - adj;
					end else begin
						high_fix = flags_s1.c || (operand_s1 > DAA_HIGH_LIMIT);
						adj = ((flags_s1.h || (operand_s1[3:0] > DAA_LOW_LIMIT))
						       ? DAA_LOW_ADJ : 8'h00)
						    | (high_fix ? DAA_HIGH_ADJ : 8'h00);
						res_c.value   = operand_s1 + adj;
						res_c.flags.c = high_fix;
					end
					res_c.flags.z = (res_c.value == 8'h00);
					res_c.flags.h = 1'b0;
				end
				ACC_CPL:  begin
					res_c.value   = ~operand_s1;
					res_c.flags.n = 1'b1;
					res_c.flags.h = 1'b1;
				end
				ACC_SCF:  begin
					res_c.writes_back = 1'b0;
					res_c.flags.n     = 1'b0;
					res_c.flags.h     = 1'b0;
					res_c.flags.c     = 1'b1;
				end
				ACC_CCF:  begin
					res_c.writes_back = 1'b0;
					res_c.flags.n     = 1'b0;
					res_c.flags.h     = 1'b0;
					res_c.flags.c     = !flags_s1.c;
				end
			endcase
		end
	end

	// Pack the result register onto the output bus.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.cycles, res_s2.flags.c, res_s2.flags.h, res_s2.flags.n,
	                   res_s2.flags.z, res_s2.writes_back, res_s2.value};

	// A stage 1 item with room ahead must show up at the output next cycle.
	`RSBF_ASSERT_NEXT(a_adv_fills_out, adv_s1, m_tvalid, "stage 1 item lost on advance")
	// A blocked stage 1 item must stay put.
	`RSBF_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1, "stage 1 item dropped")
	// The machine cycle field always holds one of the CYC_ constants of the package.
	`RSBF_ASSERT_IMPL(a_cyc_range, m_tvalid,
		(m_tdata[15:13] == CYC_ACC) || (m_tdata[15:13] == CYC_CB_REG) ||
		(m_tdata[15:13] == CYC_BIT_MEM) || (m_tdata[15:13] == CYC_CB_MEM),
		"machine cycle count out of range")
	// CYC_BIT_MEM only arises from a memory BIT test, which never writes back.
	`RSBF_ASSERT_IMPL(a_bit_no_wb, m_tvalid && (m_tdata[15:13] == CYC_BIT_MEM),
		!m_tdata[8], "BIT test marked for write back")

endmodule

`default_nettype wire
